>>> sv/variable_record_ring_queue_macros.svh
// Assertion macros shared by the ring queue RTL.
// Included by modules that check their own invariants; no other dependencies.
`ifndef VARIABLE_RECORD_RING_QUEUE_MACROS_SVH
`define VARIABLE_RECORD_RING_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk except while rst is high.
`define VRRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define VRRQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VRRQ_ASSERT(lbl, prop, msg)
`define VRRQ_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> sv/vrrq_pkg.sv
// Types and constants for the variable record ring queue.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package vrrq_pkg;

  typedef logic [2:0] op_code_t;
  typedef logic [1:0] status_t;

  localparam op_code_t OP_START   = 3'd0;
  localparam op_code_t OP_PAYLOAD = 3'd1;
  localparam op_code_t OP_PEEK    = 3'd2;
  localparam op_code_t OP_READ    = 3'd3;
  localparam op_code_t OP_POP     = 3'd4;
  localparam op_code_t OP_CLEAR   = 3'd5;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_MISUSE = 2'd3;

  // Every record starts with identifier low/high and length low/high.
  localparam int HDR_BYTES = 4;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_HDR_WR  = 4'b0010,
    S_HDR_RD  = 4'b0100,
    S_BYTE_RD = 4'b1000
  } state_t;

endpackage

>>> sv/vrrq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module vrrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/variable_record_ring_queue.sv
// Variable record ring queue: byte ring of header-plus-payload records.
// Depends on vrrq_pkg, vrrq_ram and variable_record_ring_queue_macros.svh.
`timescale 1ns / 1ps
`include "variable_record_ring_queue_macros.svh"

// Usage
// The input channel (in_valid, in_stall) carries one command word: op plus
// identifier, length, data_byte and capacity. The output channel (out_valid,
// out_stall) returns exactly one result word per command, in command order.
// All record bytes live in one byte-wide RAM with one write and one read port
// and a registered read, so the path to the result depends on the command:
//   payload byte, clear and every rejected command: result registered at accept.
//   start enqueue that succeeds: one header byte at accept, the rest in S_HDR_WR.
//   peek and pop of a held record: four header byte reads in S_HDR_RD behind
//   the registered RAM read.
//   read byte: one RAM read, result from S_BYTE_RD.
// Streaming payload in therefore runs at one byte per cycle with payload and clear
// commands while out_stall is low; each read byte waits in S_BYTE_RD for its result.
// One command is in flight at a time. The result sits in an output register;
// the next command is taken in the same cycle that the result is taken. While
// the receiver stalls, the result holds and in_stall stays high.
// Reset (synchronous, active high) empties the queue, closes any open record
// and read, and drops a pending result. The RAM is not cleared: no entry is
// ever read before it is written, so no clearing pass is needed.
module variable_record_ring_queue
  import vrrq_pkg::*;
#(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [15:0] identifier,
  input  logic [15:0] length,
  input  logic [7:0]  data_byte,
  input  logic [15:0] capacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] head_identifier,
  output logic [15:0] head_length,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic [10:0] record_count,
  output logic [12:0] bytes_used
);

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int POS_W  = $clog2(BUFFER_BYTES + 1);
  localparam int CNT_W  = $clog2(BUFFER_BYTES / HDR_BYTES + 1);
  localparam int SZ_W   = 17;
  // Wide enough for a position plus a record size without overflow.
  localparam int AW     = ((POS_W > SZ_W) ? POS_W : SZ_W) + 1;
  localparam logic [AW-1:0]    BUF_A = AW'(BUFFER_BYTES);
  localparam logic [AW-1:0]    HDR_A = AW'(HDR_BYTES);
  localparam logic [POS_W-1:0] BUF_P = POS_W'(BUFFER_BYTES);
  localparam logic [POS_W-1:0] HDR_P = POS_W'(HDR_BYTES);

  state_t state;

  // Queue bookkeeping.
  logic [POS_W-1:0] insert_position;
  logic [POS_W-1:0] terminal_position;
  logic [POS_W-1:0] head_position;
  logic [POS_W-1:0] used_bytes;
  logic [CNT_W-1:0] records_held;
  logic [15:0]      write_remaining;
  logic [15:0]      wr_total;
  logic [POS_W-1:0] wr_ptr;
  logic [POS_W-1:0] read_cursor;
  logic [15:0]      read_remaining;

  // Working registers of a multi-cycle command.
  logic [POS_W-1:0] hdr_base;
  logic [15:0]      hdr_id;
  logic [15:0]      hdr_len;
  logic [1:0]       hw_idx;
  logic [1:0]       rd_idx;
  logic             pend_pop;
  logic [15:0]      pend_cap;
  logic             rd_last;
  logic             rd_zero;

  // RAM ports.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  logic [POS_W-1:0]  wr_pos;
  logic              wr_en;
  logic [POS_W-1:0]  rd_pos;
  logic [7:0]        rbyte;

  logic accept;

  // Start enqueue space check.
  logic [AW-1:0]    size_a;
  logic [AW-1:0]    ins_a;
  logic [AW-1:0]    head_a;
  logic             start_full;
  logic             start_wrap;
  logic [POS_W-1:0] start_base;

  // Peek and pop lazy wrap.
  logic             pk_wrap;
  logic [POS_W-1:0] pk_head;

  // Record commit.
  logic [POS_W-1:0] cm_base;
  logic [AW-1:0]    cm_size_a;
  logic [AW-1:0]    cm_ins_a;
  logic [POS_W-1:0] cm_ins;
  logic [POS_W-1:0] cm_term;
  logic [POS_W-1:0] cm_used;

  // Header read completion.
  logic [15:0]      rl;
  logic [15:0]      rep_len;
  logic [AW-1:0]    p_size_a;
  logic [POS_W-1:0] p_used;
  logic [POS_W-1:0] p_head;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign record_count = 11'(records_held);
  assign bytes_used   = 13'(used_bytes);

  // Space rules of start enqueue, evaluated on the current positions.
  always_comb begin
    size_a     = AW'(length) + HDR_A;
    ins_a      = AW'(insert_position);
    head_a     = AW'(head_position);
    start_full = 1'b0;
    start_wrap = 1'b0;
    if (AW'(used_bytes) + size_a > BUF_A) begin
      start_full = 1'b1;
    end else if (insert_position == terminal_position && ins_a + size_a > BUF_A) begin
      if (head_a >= size_a) begin
        start_wrap = 1'b1;
      end else begin
        start_full = 1'b1;
      end
    end else if (insert_position < terminal_position && ins_a + size_a >= head_a) begin
      start_full = 1'b1;
    end
    start_base = start_wrap ? '0 : insert_position;
  end

  assign pk_wrap = (head_position == terminal_position);
  assign pk_head = pk_wrap ? '0 : head_position;

  // A zero-length record commits at start enqueue; otherwise it commits on
  // its last payload byte.
  always_comb begin
    if (state == S_IDLE && op == OP_START) begin
      cm_base   = start_base;
      cm_size_a = HDR_A;
    end else begin
      cm_base   = insert_position;
      cm_size_a = AW'(wr_total) + HDR_A;
    end
    cm_ins_a = AW'(cm_base) + cm_size_a;
    cm_ins   = POS_W'(cm_ins_a);
    cm_term  = (cm_ins_a > AW'(terminal_position)) ? cm_ins : terminal_position;
    cm_used  = POS_W'(AW'(used_bytes) + cm_size_a);
  end

  // The length high byte arrives from the RAM in the last header read cycle.
  always_comb begin
    rl       = {rbyte, hdr_len[7:0]};
    rep_len  = (pend_cap < rl) ? 16'd0 : rl;
    p_size_a = AW'(rl) + HDR_A;
    p_used   = (p_size_a > AW'(used_bytes)) ? '0 : POS_W'(AW'(used_bytes) - p_size_a);
    p_head   = POS_W'(AW'(hdr_base) + p_size_a);
  end

  // Write port: first header byte at accept, the rest in S_HDR_WR, payload
  // bytes at accept.
  always_comb begin
    wr_en     = 1'b0;
    wr_pos    = wr_ptr;
    mem_wdata = data_byte;
    if (state == S_HDR_WR) begin
      wr_en  = 1'b1;
      wr_pos = POS_W'(hdr_base + POS_W'(hw_idx));
      case (hw_idx)
        2'd1:    mem_wdata = hdr_id[15:8];
        2'd2:    mem_wdata = hdr_len[7:0];
        default: mem_wdata = hdr_len[15:8];
      endcase
    end else if (accept && op == OP_START && write_remaining == 16'd0 && !start_full) begin
      wr_en     = 1'b1;
      wr_pos    = start_base;
      mem_wdata = identifier[7:0];
    end else if (accept && op == OP_PAYLOAD && write_remaining != 16'd0) begin
      wr_en = 1'b1;
    end
  end

  assign mem_we    = wr_en && (wr_pos < BUF_P);
  assign mem_waddr = wr_pos[ADDR_W-1:0];

  // Read port: positions past the buffer read as zero.
  always_comb begin
    rd_pos = read_cursor;
    if (state == S_HDR_RD) begin
      rd_pos = POS_W'(hdr_base + POS_W'(rd_idx) + POS_W'(1));
    end else if (accept && (op == OP_PEEK || op == OP_POP)) begin
      rd_pos = pk_head;
    end
  end

  assign mem_raddr = rd_pos[ADDR_W-1:0];
  assign rbyte     = rd_zero ? 8'd0 : mem_rdata;

  vrrq_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_ring (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    rd_zero <= (rd_pos >= BUF_P);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      insert_position   <= '0;
      terminal_position <= '0;
      head_position     <= '0;
      used_bytes        <= '0;
      records_held      <= '0;
      write_remaining   <= '0;
      wr_total          <= '0;
      wr_ptr            <= '0;
      read_cursor       <= '0;
      read_remaining    <= '0;
      hw_idx            <= '0;
      rd_idx            <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // Commands finished at accept report right away; those that go on
            // to a busy state clear out_valid again below.
            out_valid       <= 1'b1;
            status          <= ST_OK;
            head_identifier <= '0;
            head_length     <= '0;
            out_byte        <= '0;
            last_byte       <= 1'b0;
            case (op)
              OP_START: begin
                if (write_remaining != 16'd0) begin
                  status <= ST_MISUSE;
                end else if (start_full) begin
                  status <= ST_FULL;
                end else begin
                  out_valid       <= 1'b0;
                  state           <= S_HDR_WR;
                  hw_idx          <= 2'd1;
                  hdr_base        <= start_base;
                  hdr_id          <= identifier;
                  hdr_len         <= length;
                  insert_position <= start_base;
                  write_remaining <= length;
                  wr_total        <= length;
                  wr_ptr          <= POS_W'(start_base + HDR_P);
                  if (length == 16'd0) begin
                    records_held      <= records_held + CNT_W'(1);
                    used_bytes        <= cm_used;
                    insert_position   <= cm_ins;
                    terminal_position <= cm_term;
                  end
                end
              end
              OP_PAYLOAD: begin
                if (write_remaining == 16'd0) begin
                  status <= ST_MISUSE;
                end else begin
                  wr_ptr          <= wr_ptr + POS_W'(1);
                  write_remaining <= write_remaining - 16'd1;
                  if (write_remaining == 16'd1) begin
                    records_held      <= records_held + CNT_W'(1);
                    used_bytes        <= cm_used;
                    insert_position   <= cm_ins;
                    terminal_position <= cm_term;
                  end
                end
              end
              OP_PEEK, OP_POP: begin
                if (records_held == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  if (pk_wrap) begin
                    head_position     <= '0;
                    terminal_position <= insert_position;
                  end
                  out_valid <= 1'b0;
                  state     <= S_HDR_RD;
                  rd_idx    <= 2'd0;
                  hdr_base  <= pk_head;
                  pend_pop  <= (op == OP_POP);
                  pend_cap  <= capacity;
                end
              end
              OP_READ: begin
                if (read_remaining == 16'd0) begin
                  status <= ST_MISUSE;
                end else begin
                  out_valid      <= 1'b0;
                  state          <= S_BYTE_RD;
                  read_cursor    <= read_cursor + POS_W'(1);
                  read_remaining <= read_remaining - 16'd1;
                  rd_last        <= (read_remaining == 16'd1);
                end
              end
              OP_CLEAR: begin
                insert_position   <= '0;
                terminal_position <= '0;
                head_position     <= '0;
                used_bytes        <= '0;
                records_held      <= '0;
                write_remaining   <= '0;
                read_cursor       <= '0;
                read_remaining    <= '0;
              end
              default: begin
                status <= ST_MISUSE;
              end
            endcase
          end
        end
        S_HDR_WR: begin
          hw_idx <= hw_idx + 2'd1;
          if (hw_idx == 2'd3) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        S_HDR_RD: begin
          rd_idx <= rd_idx + 2'd1;
          case (rd_idx)
            2'd0: hdr_id[7:0]  <= rbyte;
            2'd1: hdr_id[15:8] <= rbyte;
            2'd2: hdr_len[7:0] <= rbyte;
            default: begin
              state           <= S_IDLE;
              out_valid       <= 1'b1;
              head_identifier <= hdr_id;
              head_length     <= rep_len;
              if (pend_pop) begin
                records_held   <= records_held - CNT_W'(1);
                used_bytes     <= p_used;
                head_position  <= p_head;
                read_remaining <= '0;
              end else begin
                read_cursor    <= POS_W'(hdr_base + HDR_P);
                read_remaining <= rep_len;
              end
            end
          endcase
        end
        S_BYTE_RD: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          out_byte  <= rbyte;
          last_byte <= rd_last;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `VRRQ_ASSERT(a_busy_no_result, (state != S_IDLE) |-> !out_valid, "result shown while busy")
  `VRRQ_ASSERT(a_used_bound, used_bytes <= BUF_P, "bytes held exceed the buffer")
  `VRRQ_ASSERT(a_last_closes_read, (out_valid && last_byte) |-> (read_remaining == 16'd0), "last byte with read still open")
  `VRRQ_ASSERT_RST(a_reset_idle, rst |=> (!out_valid && state == S_IDLE), "not idle after reset")

endmodule
